### design/hex_rp_pkg.sv
`timescale 1ns / 1ps

package hex_rp_pkg;

   localparam logic       KIND_WRITE     = 1'b0;
   localparam logic       KIND_SUM       = 1'b1;
   localparam logic [15:0] BASE_RESET    = 16'h0800;
   localparam logic [9:0] POS_COUNT      = 10'd2;
   localparam logic [9:0] POS_ADDR_HIGH  = 10'd4;
   localparam logic [9:0] POS_ADDR_LOW   = 10'd6;
   localparam logic [9:0] POS_FIRST_DATA = 10'd10;

   typedef struct packed {
      logic [7:0] character;
      logic       record_start;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] flash_address;
      logic [15:0] halfword;
      logic [7:0]  sum_computed;
      logic [7:0]  sum_received;
      logic        sum_match;
   } rsp_type;

   // Upper-case hex digits only; every other character reads as zero.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'd55;
      end
      return v[3:0];
   endfunction

endpackage

### design/hex_record_parser_core.sv
`timescale 1ns / 1ps

// Channel   Ports                              Moves
// input     req_valid, req_ready, req_data     one record character per item
// result    rsp_valid, rsp_ready, rsp_data     halfword write or checksum report
// config    csr_wr_en, csr_wr_data             flash base upper 16 bits
//
// One input item is taken per cycle while req_ready is high; its result, if any,
// is registered into the output queue and reaches the result channel in turn.
// A two-entry output queue holds results, so input keeps flowing while one
// result waits; req_ready drops only when both entries are full.
// Synchronous reset closes any open record and sets the base to 0x0800.

module hex_record_parser_core import hex_rp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] base_ff;
   logic        push;
   rsp_type     push_data;
   logic        has_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   assign req_ready = has_room;

   hex_rp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (req_valid && has_room),
      .in_data    (req_data),
      .base_upper (base_ff),
      .push       (push),
      .push_data  (push_data)
   );

   hex_rp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

### design/hex_rp_parse.sv
`timescale 1ns / 1ps

module hex_rp_parse import hex_rp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_accept,
   input  req_type     in_data,
   input  logic [15:0] base_upper,
   output logic        push,
   output rsp_type     push_data
);

   logic [9:0]  pos_ff, pos_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] offset_ff, offset_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  sum_ff, sum_in;
   logic        done_ff, done_in;

   logic [9:0]  pos_next;
   logic [9:0]  data_pos;
   logic [8:0]  k;
   logic [3:0]  nib;
   logic [7:0]  byte_val;
   logic [7:0]  computed;
   logic        has_result;
   rsp_type     result;

   always_comb begin
      pos_next = pos_ff + 10'd1;
      data_pos = pos_next - POS_FIRST_DATA;
      k        = data_pos[9:1];
      nib      = hex_value(in_data.character);
      byte_val = {nibble_ff, nib};
      computed = (~sum_ff) + 8'd1;

      pos_in     = pos_ff;
      count_in   = count_ff;
      offset_in  = offset_ff;
      nibble_in  = nibble_ff;
      low_in     = low_ff;
      sum_in     = sum_ff;
      done_in    = done_ff;
      has_result = 1'b0;
      result     = '0;

      priority if (in_data.record_start) begin
         pos_in    = '0;
         count_in  = '0;
         offset_in = '0;
         nibble_in = '0;
         low_in    = '0;
         sum_in    = '0;
         done_in   = 1'b0;
      end else if (!done_ff) begin
         pos_in = pos_next;
         priority if (pos_next[0]) begin
            nibble_in = nib;
         end else if (pos_next == POS_COUNT) begin
            count_in = byte_val;
            sum_in   = sum_ff + byte_val;
         end else if (pos_next == POS_ADDR_HIGH) begin
            offset_in = {byte_val, offset_ff[7:0]};
            sum_in    = sum_ff + byte_val;
         end else if (pos_next == POS_ADDR_LOW) begin
            offset_in = {offset_ff[15:8], byte_val};
            sum_in    = sum_ff + byte_val;
         end else if (pos_next >= POS_FIRST_DATA) begin
            if (k >= {1'b0, count_ff}) begin
               // Checksum byte closes the record.
               done_in             = 1'b1;
               has_result          = 1'b1;
               result.result_kind  = KIND_SUM;
               result.sum_computed = computed;
               result.sum_received = byte_val;
               result.sum_match    = (computed == byte_val);
            end else begin
               sum_in = sum_ff + byte_val;
               if (!k[0]) begin
                  low_in = byte_val;
               end else begin
                  has_result           = 1'b1;
                  result.result_kind   = KIND_WRITE;
                  result.flash_address = {base_upper, offset_ff}
                                       + {23'd0, k[8:1], 1'b0};
                  result.halfword      = {byte_val, low_ff};
               end
            end
         end else begin
            // Record type byte.
            sum_in = sum_ff + byte_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         count_ff  <= '0;
         offset_ff <= '0;
         nibble_ff <= '0;
         low_ff    <= '0;
         sum_ff    <= '0;
         done_ff   <= 1'b1;
      end else if (in_accept) begin
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
         nibble_ff <= nibble_in;
         low_ff    <= low_in;
         sum_ff    <= sum_in;
         done_ff   <= done_in;
      end
   end

   assign push      = in_accept && has_result;
   assign push_data = result;

   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      in_accept && in_data.record_start |=> !done_ff && pos_ff == '0)
      else $error("start item did not open a record");

   a_sum_closes: assert property (@(posedge clock) disable iff (reset)
      push && push_data.result_kind == KIND_SUM |=> done_ff)
      else $error("checksum report left the record open");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      done_ff && !in_data.record_start |-> !push)
      else $error("result produced outside a record");

endmodule

### design/hex_rp_outq.sv
`timescale 1ns / 1ps

module hex_rp_outq import hex_rp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    has_room,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign has_room  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push)
      else $error("push into a full output queue");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("output queue lost track of a pop");

endmodule

### verif/hex_record_parser_core_tb.sv
`timescale 1ns / 1ps

module hex_record_parser_core_tb;
   import hex_rp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_CHARS = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   hex_record_parser_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Parser state as the block should hold it.
   logic [15:0] base_upper = BASE_RESET;
   logic [9:0]  char_pos = '0;
   logic [7:0]  data_len = '0;
   logic [15:0] load_offset = '0;
   logic [3:0]  high_nibble = '0;
   logic [7:0]  even_byte = '0;
   logic [7:0]  byte_total = '0;
   logic        record_closed = 1'b1;

   req_type pending_chars[$];
   rsp_type expected_results[$];

   int sender_idle_pct = 20;
   int receiver_idle_pct = 48;
   int hold_requests = 0;
   int holds_begun = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int failures = 0;
   int chars_queued = 0;
   int records_opened = 0;
   int writes_seen = 0;
   int sums_seen = 0;
   int mismatched_sums = 0;

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return 4'(c - 8'h30);
      end
      if (c >= "A" && c <= "F") begin
         return 4'(c - 8'h41 + 8'd10);
      end
      return 4'h0;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
   endfunction

   task automatic decode_char(input req_type item);
      logic [3:0] nib;
      logic [7:0] value;
      logic [9:0] byte_index;
      rsp_type    result;
      if (item.record_start) begin
         char_pos = '0;
         data_len = '0;
         load_offset = '0;
         high_nibble = '0;
         even_byte = '0;
         byte_total = '0;
         record_closed = 1'b0;
      end else if (!record_closed) begin
         char_pos = char_pos + 10'd1;
         nib = digit_value(item.character);
         if (char_pos[0]) begin
            high_nibble = nib;
         end else begin
            value = {high_nibble, nib};
            byte_index = (char_pos - POS_FIRST_DATA) >> 1;
            result = '0;
            if (char_pos >= POS_FIRST_DATA && byte_index >= 10'(data_len)) begin
               // The byte after the last data byte is the checksum.
               result.result_kind = KIND_SUM;
               result.sum_computed = ~byte_total + 8'd1;
               result.sum_received = value;
               result.sum_match = (result.sum_computed == value);
               record_closed = 1'b1;
               expected_results.push_back(result);
            end else begin
               byte_total = byte_total + value;
               if (char_pos == POS_COUNT) begin
                  data_len = value;
               end else if (char_pos == POS_ADDR_HIGH) begin
                  load_offset[15:8] = value;
               end else if (char_pos == POS_ADDR_LOW) begin
                  load_offset[7:0] = value;
               end else if (char_pos >= POS_FIRST_DATA) begin
                  if (!byte_index[0]) begin
                     even_byte = value;
                  end else begin
                     result.result_kind = KIND_WRITE;
                     result.flash_address = {base_upper, load_offset}
                                            + 32'(byte_index - 10'd1);
                     result.halfword = {value, even_byte};
                     expected_results.push_back(result);
                  end
               end
            end
         end
      end
   endtask

   // The item at the head of the queue stays on the bus until it is taken.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         decode_char(req_data);
         void'(pending_chars.pop_front());
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_chars[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_begun != hold_requests) begin
         holds_begun = holds_begun + 1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", field, want, got);
         failures++;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         $error("result arrived with nothing outstanding: %h", got);
         failures++;
      end else begin
         want = expected_results.pop_front();
         compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
         compare_field("flash_address", want.flash_address, got.flash_address);
         compare_field("halfword", 32'(want.halfword), 32'(got.halfword));
         compare_field("sum_computed", 32'(want.sum_computed), 32'(got.sum_computed));
         compare_field("sum_received", 32'(want.sum_received), 32'(got.sum_received));
         compare_field("sum_match", 32'(want.sum_match), 32'(got.sum_match));
         if (want.result_kind == KIND_SUM) begin
            sums_seen++;
            if (!want.sum_match) begin
               mismatched_sums++;
            end
         end else begin
            writes_seen++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic push_char(input logic [7:0] c, input logic start);
      req_type item;
      item.character = c;
      item.record_start = start;
      pending_chars.push_back(item);
      chars_queued++;
      if (start) begin
         records_opened++;
      end
   endtask

   task automatic push_text(input string s, input bit opens);
      for (int i = 0; i < s.len(); i++) begin
         push_char(s[i], opens && i == 0);
      end
   endtask

   task automatic push_digit(input logic [3:0] n, input bit mangle);
      logic [7:0] c;
      c = hex_digit(n);
      if (mangle && $urandom_range(19) == 0) begin
         c = $urandom_range(1) ? 8'(8'h61 + $urandom_range(5)) : 8'($urandom_range(255));
      end
      push_char(c, 1'b0);
   endtask

   // A cut of -1 sends the whole record; otherwise only that many digits follow the start.
   task automatic push_record(input int count, input logic [15:0] addr,
                              input logic [7:0] rtype, input bit good_sum,
                              input int cut, input bit mangle);
      logic [7:0] record_bytes[$];
      logic [7:0] total;
      record_bytes = {8'(count), addr[15:8], addr[7:0], rtype};
      for (int i = 0; i < count; i++) begin
         record_bytes.push_back(8'($urandom_range(255)));
      end
      total = '0;
      foreach (record_bytes[i]) begin
         total = total + record_bytes[i];
      end
      record_bytes.push_back(good_sum ? 8'(~total + 8'd1) : 8'($urandom_range(255)));
      push_char(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : ":", 1'b1);
      for (int d = 0; d < 2 * record_bytes.size(); d++) begin
         if (d == cut) begin
            break;
         end
         if (d % 2 == 0) begin
            push_digit(record_bytes[d / 2][7:4], mangle);
         end else begin
            push_digit(record_bytes[d / 2][3:0], mangle);
         end
      end
   endtask

   task automatic random_record();
      int pick;
      int size_pick;
      int count;
      logic [15:0] addr;
      logic [7:0]  rtype;
      pick = $urandom_range(99);
      size_pick = $urandom_range(99);
      if (size_pick == 0) begin
         count = 255;
      end else if (size_pick < 8) begin
         count = 0;
      end else if (size_pick < 14) begin
         count = $urandom_range(64, 17);
      end else begin
         count = $urandom_range(16, 1);
      end
      case ($urandom_range(7))
         0: begin
            addr = 16'h0000;
         end
         1: begin
            addr = 16'hFFFF;
         end
         2: begin
            addr = 16'hFFFE;
         end
         default: begin
            addr = 16'($urandom_range(65535));
         end
      endcase
      rtype = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
      if (pick < 85) begin
         push_record(count, addr, rtype, pick < 75, -1, pick >= 65 && pick < 75);
         if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(3, 1)) push_char(8'($urandom_range(255)), 1'b0);
         end
      end else if (pick < 93) begin
         push_record(count, addr, rtype, 1'b1, $urandom_range(2 * count + 9), 1'b0);
      end else begin
         repeat ($urandom_range(8, 1)) push_char(8'($urandom_range(255)), 1'b0);
      end
   endtask

   // A character that closes no pair still updates state inside the block, so wait on past the last result.
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_chars.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_base(input logic [15:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      base_upper = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input logic [15:0] base,
                            input bit stall_receiver);
      int target;
      write_base(base);
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      if (stall_receiver) begin
         hold_requests++;
      end
      target = chars_queued + PHASE_CHARS;
      while (chars_queued < target) begin
         random_record();
         while (pending_chars.size() > 64) begin
            @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Nothing is open yet, so these are dropped.
      push_char("7", 1'b0);
      push_char(8'hFF, 1'b0);
      push_char(8'h00, 1'b0);
      // Empty end-of-file record with a good checksum; the line ending is ignored.
      push_text(":00000001FF\r\n", 1'b1);
      // Three data bytes: the third is summed but never written.
      push_text(":03FFFF0000FF7A00", 1'b1);
      // Bad checksum.
      push_text(":0100000055AB", 1'b1);
      // Lower case and non-hex digits read as zero; the record is then cut by a new start.
      push_text(":04001000a19GxyZ0", 1'b1);
      // Leave a record open across a base change.
      push_text(":0400200000AABB", 1'b1);
      write_base(16'hFFFF);
      push_text("CCDD11", 1'b0);
      // Addresses run past the top of the 32-bit space and wrap.
      push_text(":04FFFE0012345678XX", 1'b1);
      push_record(255, 16'hFFFF, 8'hFF, 1'b1, -1, 1'b0);

      run_phase(20, 48, 16'h0000, 1'b0);
      run_phase(20, 48, 16'($urandom_range(65535)), 1'b0);
      run_phase(48, 20, 16'hFFFF, 1'b0);
      run_phase(48, 20, 16'($urandom_range(65535)), 1'b0);
      run_phase(0, 0, BASE_RESET, 1'b1);
      run_phase(0, 0, 16'($urandom_range(65535)), 1'b0);
      wait_idle();

      $display("Sent %0d characters opening %0d records with seven base register writes.",
               chars_queued, records_opened);
      $display("Checked %0d halfword writes and %0d checksum reports (%0d mismatched).",
               writes_seen, sums_seen, mismatched_sums);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
